>>> design/toqm_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// toqm_pkg: shared constants for the timestamp ordered merge.
// Holds the command and result codes, register indexes and default sizes.
// ---------------------------------------------------------------------------
package toqm_pkg;

    localparam int NumSlotsDef  = 4;
    localparam int SlotDepthDef = 8;
    localparam int NumTrajDef   = 4;
    localparam int TimeBitsDef  = 48;

    // Command codes.
    localparam logic [1:0] CMD_PUSH   = 2'd0;
    localparam logic [1:0] CMD_FINISH = 2'd1;
    localparam logic [1:0] CMD_FLUSH  = 2'd2;

    // Result kinds.
    localparam logic [2:0] KIND_ITEM    = 3'd0;
    localparam logic [2:0] KIND_BLOCKED = 3'd1;
    localparam logic [2:0] KIND_DONE    = 3'd2;
    localparam logic [2:0] KIND_IGNORED = 3'd3;
    localparam logic [2:0] KIND_OVERFLW = 3'd4;
    localparam logic [2:0] KIND_ORDER   = 3'd5;

    // Configuration register indexes.
    localparam logic [2:0] REG_LIVE  = 3'd0;
    localparam logic [2:0] REG_TRAJ0 = 3'd1;
    localparam logic [2:0] REG_TRAJ3 = 3'd4;

endpackage

>>> design/timestamp_ordered_queue_merge.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// timestamp_ordered_queue_merge: k-way timestamp merge of sensor queues.
// Per-slot queues live in one synchronous memory; a sequencer scans the
// slot heads and sends items in time order after each command.
// ---------------------------------------------------------------------------
// Usage: a command (push, finish, flush) is taken when start is high and
// busy is low. Every command gives zero or more results, each shown for
// one cycle with o_valid high; o_last marks the final one. The receiver
// cannot hold results off. Configuration writes use i_cfg_valid/o_cfg_ready
// and are accepted only while the block is idle.
// A rejected command shows its result in the cycle after acceptance. A
// dispatch round scans every slot head through the queue memory, reading
// then comparing each one; a command costs one round per item sent plus
// one closing round, and a drop of a stale head costs one more memory
// read. The first service of a trajectory adds a start time pass. The next
// command is taken once the block is idle again.
// Reset clears all pointers, flags, start times and the last sent time; the
// queue memory itself is not cleared and needs no clearing pass.
// ---------------------------------------------------------------------------
module timestamp_ordered_queue_merge #(
    parameter int NUM_SLOTS  = toqm_pkg::NumSlotsDef,
    parameter int SLOT_DEPTH = toqm_pkg::SlotDepthDef,
    parameter int NUM_TRAJ   = toqm_pkg::NumTrajDef,
    parameter int TIME_BITS  = toqm_pkg::TimeBitsDef
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  i_cmd,
    input  logic [1:0]  i_slot,
    input  logic [47:0] i_timestamp,
    input  logic [31:0] i_payload,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [3:0]  i_cfg_data,
    output logic        o_valid,
    output logic [2:0]  o_kind,
    output logic [1:0]  o_out_slot,
    output logic [47:0] o_out_timestamp,
    output logic [31:0] o_out_payload,
    output logic        o_last
);

    localparam int SW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int PW = $clog2(SLOT_DEPTH);
    localparam int CW = $clog2(SLOT_DEPTH + 1);
    localparam int TW = (NUM_TRAJ > 1) ? $clog2(NUM_TRAJ) : 1;
    localparam int AW = $clog2(NUM_SLOTS * SLOT_DEPTH);
    localparam int DEPTH = NUM_SLOTS * SLOT_DEPTH;
    localparam int CNTW = $clog2(NUM_SLOTS + 1);

    typedef enum logic [9:0] {
        S_IDLE  = 10'b0000000001,
        S_SCAN  = 10'b0000000010,
        S_CMP   = 10'b0000000100,
        S_DEC   = 10'b0000001000,
        S_STRD  = 10'b0000010000,
        S_STCMP = 10'b0000100000,
        S_ACT   = 10'b0001000000,
        S_NEXT  = 10'b0010000000,
        S_NXCMP = 10'b0100000000,
        S_EMIT  = 10'b1000000000
    } t_state;

    // Queue memory: timestamp and payload of each entry.
    logic [TIME_BITS-1:0] r_mem_t [DEPTH];
    logic [31:0]          r_mem_w [DEPTH];
    logic [TIME_BITS-1:0] r_rd_t;
    logic [31:0]          r_rd_w;

    logic [PW-1:0] r_rptr [NUM_SLOTS];
    logic [PW-1:0] r_wptr [NUM_SLOTS];
    logic [CW-1:0] r_fill [NUM_SLOTS];
    logic [NUM_SLOTS-1:0] r_fin, r_ret, r_live;
    logic [TW-1:0] r_traj [NUM_SLOTS];
    logic [NUM_TRAJ-1:0] r_sknown;
    logic [TIME_BITS-1:0] r_stime [NUM_TRAJ];
    logic [TIME_BITS-1:0] r_last_sent;

    t_state r_state;
    logic [CNTW-1:0] r_idx;
    logic            r_have;
    logic [SW-1:0]   r_best;
    logic [TIME_BITS-1:0] r_bt, r_st;

    // Payload of the popped head kept while the following entry is read.
    logic [31:0] r_rd_w_hold;

    // Memory access control from the sequencer.
    logic          mem_we, mem_re;
    logic [AW-1:0] mem_wa, mem_ra;

    logic [SW-1:0] idx_s;
    logic          idx_act;
    assign idx_s   = r_idx[SW-1:0];
    assign idx_act = r_live[idx_s] && !r_ret[idx_s];

    function automatic logic [AW-1:0] addr_of(input logic [SW-1:0] s, input logic [PW-1:0] p);
        return AW'(s) * AW'(SLOT_DEPTH) + AW'(p);
    endfunction

    function automatic logic [PW-1:0] inc_ptr(input logic [PW-1:0] p);
        return (32'(p) + 1 >= SLOT_DEPTH) ? '0 : PW'(32'(p) + 1);
    endfunction

    // Bring a trajectory number into range by repeated subtraction.
    function automatic logic [TW-1:0] traj_wrap(input logic [1:0] v);
        int unsigned x;
        x = 32'(v);
        for (int i = 0; i < 3; i++) begin
            if (x >= 32'(NUM_TRAJ)) x = x - 32'(NUM_TRAJ);
        end
        return TW'(x);
    endfunction

    // Synchronous memory with registered read.
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem_t[mem_wa] <= TIME_BITS'(i_timestamp);
            r_mem_w[mem_wa] <= i_payload;
        end
        if (mem_re) begin
            r_rd_t <= r_mem_t[mem_ra];
            r_rd_w <= r_mem_w[mem_ra];
        end
    end

    assign busy        = (r_state != S_IDLE);
    assign o_cfg_ready = (r_state == S_IDLE) && !start;

    logic accept;
    logic [SW-1:0] in_s;
    logic          in_ok;
    assign accept = start && !busy;
    assign in_s   = SW'(i_slot);
    assign in_ok  = (32'(i_slot) < NUM_SLOTS) && r_live[in_s] && !r_ret[in_s];

    logic [SW-1:0] best_nx;
    assign best_nx = r_best;
    logic [PW-1:0] nx_ptr;
    assign nx_ptr = inc_ptr(r_rptr[best_nx]);

    always_comb begin
        mem_we = accept && i_cmd == toqm_pkg::CMD_PUSH && in_ok
                 && 32'(r_fill[in_s]) < SLOT_DEPTH;
        mem_wa = addr_of(in_s, r_wptr[in_s]);
        mem_re = 1'b0;
        mem_ra = addr_of(idx_s, r_rptr[idx_s]);
        unique case (r_state)
            S_SCAN, S_STRD: mem_re = (32'(r_idx) < NUM_SLOTS);
            S_NEXT: begin
                mem_re = 1'b1;
                mem_ra = addr_of(r_best, nx_ptr);
            end
            S_ACT: begin
                mem_re = 1'b1;
                mem_ra = addr_of(r_best, r_rptr[r_best]);
            end
            default: ;
        endcase
    end

    // Main sequencer.
    always_ff @(posedge i_clk) begin
        logic n_valid;
        logic n_last;
        n_valid = 1'b0;
        n_last  = 1'b0;
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_fin       <= '0;
            r_ret       <= '0;
            r_live      <= '0;
            r_sknown    <= '0;
            r_last_sent <= '0;
            for (int s = 0; s < NUM_SLOTS; s++) begin
                r_rptr[s] <= '0;
                r_wptr[s] <= '0;
                r_fill[s] <= '0;
                r_traj[s] <= '0;
            end
            for (int k = 0; k < NUM_TRAJ; k++) begin
                r_stime[k] <= '0;
            end
        end else begin
            // Configuration transfer.
            if (i_cfg_valid && o_cfg_ready) begin
                if (i_cfg_index == toqm_pkg::REG_LIVE) begin
                    for (int s = 0; s < NUM_SLOTS; s++) begin
                        if (s < 4 && i_cfg_data[s] != r_live[s]) begin
                            r_rptr[s] <= '0;
                            r_wptr[s] <= '0;
                            r_fill[s] <= '0;
                            r_fin[s]  <= 1'b0;
                            r_ret[s]  <= 1'b0;
                        end
                        r_live[s] <= (s < 4) ? i_cfg_data[s] : 1'b0;
                    end
                end else if (i_cfg_index >= toqm_pkg::REG_TRAJ0
                             && i_cfg_index <= toqm_pkg::REG_TRAJ3) begin
                    for (int s = 0; s < NUM_SLOTS; s++) begin
                        if (32'(i_cfg_index) - 1 == s)
                            r_traj[s] <= traj_wrap(i_cfg_data[1:0]);
                    end
                end
            end
            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_idx  <= '0;
                        r_have <= 1'b0;
                        priority if (i_cmd == toqm_pkg::CMD_PUSH) begin
                            if (!in_ok) begin
                                n_valid = 1'b1; n_last = 1'b1;
                                o_kind  <= toqm_pkg::KIND_IGNORED;
                                o_out_slot <= '0;
                            end else if (32'(r_fill[in_s]) >= SLOT_DEPTH) begin
                                n_valid = 1'b1; n_last = 1'b1;
                                o_kind  <= toqm_pkg::KIND_OVERFLW;
                                o_out_slot <= '0;
                            end else begin
                                r_wptr[in_s] <= inc_ptr(r_wptr[in_s]);
                                r_fill[in_s] <= r_fill[in_s] + CW'(1);
                                r_state <= S_SCAN;
                            end
                        end else if (i_cmd == toqm_pkg::CMD_FINISH) begin
                            if (!in_ok || r_fin[in_s]) begin
                                n_valid = 1'b1; n_last = 1'b1;
                                o_kind  <= toqm_pkg::KIND_IGNORED;
                                o_out_slot <= '0;
                            end else begin
                                r_fin[in_s] <= 1'b1;
                                r_state <= S_SCAN;
                            end
                        end else if (i_cmd == toqm_pkg::CMD_FLUSH) begin
                            if ((r_live & ~r_ret & ~r_fin) != '0) begin
                                r_fin   <= r_fin | (r_live & ~r_ret);
                                r_state <= S_SCAN;
                            end
                        end else begin
                            n_valid = 1'b1; n_last = 1'b1;
                            o_kind  <= toqm_pkg::KIND_IGNORED;
                            o_out_slot <= '0;
                        end
                        o_out_timestamp <= '0;
                        o_out_payload   <= '0;
                    end
                end
                // Scan: visit one slot and read its head; compare it when the slot has items.
                S_SCAN: begin
                    if (32'(r_idx) >= NUM_SLOTS) begin
                        if (!r_have) begin
                            n_valid = 1'b1; n_last = 1'b1;
                            o_kind  <= toqm_pkg::KIND_DONE;
                            o_out_slot <= '0;
                            o_out_timestamp <= '0;
                            o_out_payload <= '0;
                            r_state <= S_IDLE;
                        end else begin
                            r_state <= S_DEC;
                        end
                    end else if (!idx_act) begin
                        r_idx <= r_idx + CNTW'(1);
                    end else if (r_fill[idx_s] == '0) begin
                        if (r_fin[idx_s]) begin
                            r_ret[idx_s] <= 1'b1;
                            r_idx <= r_idx + CNTW'(1);
                        end else begin
                            n_valid = 1'b1; n_last = 1'b1;
                            o_kind  <= toqm_pkg::KIND_BLOCKED;
                            o_out_slot <= 2'(idx_s);
                            o_out_timestamp <= '0;
                            o_out_payload <= '0;
                            r_state <= S_IDLE;
                        end
                    end else begin
                        r_state <= S_CMP;
                    end
                end
                S_CMP: begin
                    logic [TIME_BITS-1:0] bt;
                    bt = r_bt;
                    if (!r_have || r_rd_t < r_bt) begin
                        bt     = r_rd_t;
                        r_best <= idx_s;
                    end
                    r_bt   <= bt;
                    r_have <= 1'b1;
                    if (r_last_sent > bt) begin
                        n_valid = 1'b1; n_last = 1'b1;
                        o_kind  <= toqm_pkg::KIND_ORDER;
                        o_out_slot <= 2'(idx_s);
                        o_out_timestamp <= '0;
                        o_out_payload <= '0;
                        r_state <= S_IDLE;
                    end else begin
                        r_idx   <= r_idx + CNTW'(1);
                        r_state <= S_SCAN;
                    end
                end
                // Latch the trajectory start time when it is not yet known.
                S_DEC: begin
                    if (r_sknown[r_traj[r_best]]) begin
                        r_st    <= r_stime[r_traj[r_best]];
                        r_state <= S_ACT;
                    end else begin
                        r_st    <= '0;
                        r_idx   <= '0;
                        r_state <= S_STRD;
                    end
                end
                S_STRD: begin
                    if (32'(r_idx) >= NUM_SLOTS) begin
                        r_sknown[r_traj[r_best]] <= 1'b1;
                        r_stime[r_traj[r_best]]  <= r_st;
                        r_state <= S_ACT;
                    end else if (idx_act && r_traj[idx_s] == r_traj[r_best]
                                 && r_fill[idx_s] != '0) begin
                        r_state <= S_STCMP;
                    end else begin
                        r_idx <= r_idx + CNTW'(1);
                    end
                end
                S_STCMP: begin
                    if (r_rd_t > r_st) r_st <= r_rd_t;
                    r_idx   <= r_idx + CNTW'(1);
                    r_state <= S_STRD;
                end
                // Decide between send, block and drop; head read issued here.
                S_ACT: begin
                    if (r_bt >= r_st || r_fill[r_best] < CW'(2)) begin
                        if (r_bt < r_st && !r_fin[r_best]) begin
                            n_valid = 1'b1; n_last = 1'b1;
                            o_kind  <= toqm_pkg::KIND_BLOCKED;
                            o_out_slot <= 2'(r_best);
                            o_out_timestamp <= '0;
                            o_out_payload <= '0;
                            r_state <= S_IDLE;
                        end else begin
                            r_state <= S_EMIT;
                        end
                    end else begin
                        r_state <= S_NEXT;
                    end
                end
                S_EMIT: begin
                    r_rptr[r_best] <= nx_ptr;
                    r_fill[r_best] <= r_fill[r_best] - CW'(1);
                    r_last_sent <= r_rd_t;
                    n_valid = 1'b1;
                    o_kind  <= toqm_pkg::KIND_ITEM;
                    o_out_slot <= 2'(r_best);
                    o_out_timestamp <= 48'(r_rd_t);
                    o_out_payload <= r_rd_w;
                    r_idx   <= '0;
                    r_have  <= 1'b0;
                    r_state <= S_SCAN;
                end
                // Drop path: hold popped head, read the following entry.
                S_NEXT: begin
                    r_state <= S_NXCMP;
                end
                S_NXCMP: begin
                    r_rptr[r_best] <= nx_ptr;
                    r_fill[r_best] <= r_fill[r_best] - CW'(1);
                    if (r_rd_t > r_st) begin
                        r_last_sent <= r_bt;
                        n_valid = 1'b1;
                        o_kind  <= toqm_pkg::KIND_ITEM;
                        o_out_slot <= 2'(r_best);
                        o_out_timestamp <= 48'(r_bt);
                        o_out_payload <= r_rd_w_hold;
                    end
                    r_idx   <= '0;
                    r_have  <= 1'b0;
                    r_state <= S_SCAN;
                end
                default: r_state <= S_IDLE;
            endcase
        end
        o_valid <= n_valid;
        o_last  <= n_last;
    end

    // Capture the popped head payload before the next entry overwrites it.
    always_ff @(posedge i_clk) begin
        if (r_state == S_NEXT) r_rd_w_hold <= r_rd_w;
    end

endmodule

>>> design/toqm_checker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// toqm_checker: port-level checks for the timestamp ordered merge.
// Watches the command and result ports and flags illegal sequences.
// ---------------------------------------------------------------------------
module toqm_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       start,
    input logic       busy,
    input logic       o_cfg_ready,
    input logic       o_valid,
    input logic [2:0] o_kind,
    input logic [47:0] o_out_timestamp,
    input logic       o_last
);

    // Only dispatched items carry a timestamp.
    a_ts_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_kind != toqm_pkg::KIND_ITEM |-> o_out_timestamp == '0)
        else $error("non-item result with timestamp");

    // Every result other than a dispatched item closes its command.
    a_end_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_kind != toqm_pkg::KIND_ITEM |-> o_last)
        else $error("closing result without last");

    // No configuration transfer while a command is in flight.
    a_cfg_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy |-> !o_cfg_ready)
        else $error("config ready while busy");

    // A dispatched item is never the end of a command.
    a_item_notlast: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_kind == toqm_pkg::KIND_ITEM |-> !o_last)
        else $error("item marked last");

endmodule

bind timestamp_ordered_queue_merge toqm_checker u_toqm_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
    .o_cfg_ready(o_cfg_ready), .o_valid(o_valid), .o_kind(o_kind),
    .o_out_timestamp(o_out_timestamp), .o_last(o_last)
);

>>> test/timestamp_ordered_queue_merge_test.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Timestamp ordered queue merge testbench
// Drives push, finish and flush commands through several configuration
// phases, predicts every result with a local model of the merge and checks
// each result strobe against the oldest expected result.
// ---------------------------------------------------------------------------
module timestamp_ordered_queue_merge_test;

    localparam int SLOTS = 4;
    localparam int DEPTH = 8;
    localparam int MAX_PER_CMD = SLOTS * DEPTH + 1;
    localparam int DRAIN_CYCLES = 60;
    localparam int CYCLE_LIMIT = 1000000;
    localparam logic [47:0] TS_MAX = 48'hFFFF_FFFF_FFFF;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [1:0]  slot;
        logic [47:0] ts;
        logic [31:0] word;
    } t_command;

    typedef struct packed {
        logic [2:0]  kind;
        logic [1:0]  slot;
        logic [47:0] ts;
        logic [31:0] word;
        logic        last;
    } t_merge_result;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic [1:0]  i_cmd = '0;
    logic [1:0]  i_slot = '0;
    logic [47:0] i_timestamp = '0;
    logic [31:0] i_payload = '0;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [2:0]  i_cfg_index = '0;
    logic [3:0]  i_cfg_data = '0;
    logic        o_valid;
    logic [2:0]  o_kind;
    logic [1:0]  o_out_slot;
    logic [47:0] o_out_timestamp;
    logic [31:0] o_out_payload;
    logic        o_last;

    timestamp_ordered_queue_merge i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_cmd(i_cmd), .i_slot(i_slot), .i_timestamp(i_timestamp),
        .i_payload(i_payload), .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready), .i_cfg_index(i_cfg_index),
        .i_cfg_data(i_cfg_data), .o_valid(o_valid), .o_kind(o_kind),
        .o_out_slot(o_out_slot), .o_out_timestamp(o_out_timestamp),
        .o_out_payload(o_out_payload), .o_last(o_last)
    );

    // Clock with a 4 ns period.
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    t_command      pending_cmds[$];
    t_merge_result expected_results[$];
    t_command      held_cmd;
    int            idle_pct = 0;
    int            error_count = 0;
    int            cycle_count = 0;

    // Local copy of the merge state.
    logic [47:0] q_time[SLOTS][DEPTH];
    logic [31:0] q_word[SLOTS][DEPTH];
    int          rd_idx[SLOTS];
    int          wr_idx[SLOTS];
    int          fill[SLOTS];
    bit          done_flag[SLOTS];
    bit          retired[SLOTS];
    logic [1:0]  traj_of[SLOTS];
    bit          traj_started[4];
    logic [47:0] traj_start[4];
    logic [47:0] last_sent;
    logic [3:0]  live;
    int          results_this_cmd;

    function automatic void add_result(logic [2:0] kind, int s, logic [47:0] t,
                                       logic [31:0] w);
        t_merge_result r;
        if (results_this_cmd >= MAX_PER_CMD) return;
        r.kind = kind;
        r.slot = s[1:0];
        r.ts = t;
        r.word = w;
        r.last = 1'b0;
        expected_results.insert(expected_results.size(), r);
        results_this_cmd++;
    endfunction

    function automatic void empty_slot(int s);
        rd_idx[s] = 0;
        wr_idx[s] = 0;
        fill[s] = 0;
        done_flag[s] = 1'b0;
        retired[s] = 1'b0;
    endfunction

    function automatic bit slot_active(int s);
        return live[s] && !retired[s];
    endfunction

    function automatic logic [47:0] head_of(int s, int off);
        return q_time[s][(rd_idx[s] + off) % DEPTH];
    endfunction

    function automatic void pop_head(int s, output logic [47:0] t,
                                     output logic [31:0] w);
        t = q_time[s][rd_idx[s]];
        w = q_word[s][rd_idx[s]];
        rd_idx[s] = (rd_idx[s] + 1) % DEPTH;
        fill[s]--;
    endfunction

    // Repeatedly send the oldest head until a stop condition is met.
    function automatic void merge_dispatch();
        int          best;
        logic [47:0] best_t;
        logic [47:0] st;
        logic [47:0] t;
        logic [31:0] w;
        logic [1:0]  tr;
        forever begin
            best = -1;
            best_t = '0;
            for (int s = 0; s < SLOTS; s++) begin
                if (!slot_active(s)) continue;
                if (fill[s] == 0) begin
                    if (done_flag[s]) begin
                        retired[s] = 1'b1;
                        continue;
                    end
                    add_result(toqm_pkg::KIND_BLOCKED, s, '0, '0);
                    return;
                end
                if (best < 0 || head_of(s, 0) < best_t) begin
                    best = s;
                    best_t = head_of(s, 0);
                end
                if (last_sent > best_t) begin
                    add_result(toqm_pkg::KIND_ORDER, s, '0, '0);
                    return;
                end
            end
            if (best < 0) begin
                add_result(toqm_pkg::KIND_DONE, 0, '0, '0);
                return;
            end
            tr = traj_of[best];
            // First service of a trajectory latches its latest head as start.
            if (!traj_started[tr]) begin
                st = '0;
                for (int s = 0; s < SLOTS; s++)
                    if (slot_active(s) && traj_of[s] == tr && fill[s] > 0
                        && head_of(s, 0) > st)
                        st = head_of(s, 0);
                traj_started[tr] = 1'b1;
                traj_start[tr] = st;
            end
            st = traj_start[tr];
            if (best_t >= st) begin
                pop_head(best, t, w);
                last_sent = t;
                add_result(toqm_pkg::KIND_ITEM, best, t, w);
            end else if (fill[best] < 2) begin
                if (!done_flag[best]) begin
                    add_result(toqm_pkg::KIND_BLOCKED, best, '0, '0);
                    return;
                end
                pop_head(best, t, w);
                last_sent = t;
                add_result(toqm_pkg::KIND_ITEM, best, t, w);
            end else begin
                // Stale head: kept only if its successor passes the start.
                pop_head(best, t, w);
                if (head_of(best, 0) > st) begin
                    last_sent = t;
                    add_result(toqm_pkg::KIND_ITEM, best, t, w);
                end
            end
        end
    endfunction

    function automatic void predict_merge(t_command c);
        int  s;
        bit  any;
        s = int'(c.slot);
        results_this_cmd = 0;
        if (c.cmd == toqm_pkg::CMD_PUSH) begin
            if (!slot_active(s)) begin
                add_result(toqm_pkg::KIND_IGNORED, 0, '0, '0);
            end else if (fill[s] >= DEPTH) begin
                add_result(toqm_pkg::KIND_OVERFLW, 0, '0, '0);
            end else begin
                q_time[s][wr_idx[s]] = c.ts;
                q_word[s][wr_idx[s]] = c.word;
                wr_idx[s] = (wr_idx[s] + 1) % DEPTH;
                fill[s]++;
                merge_dispatch();
            end
        end else if (c.cmd == toqm_pkg::CMD_FINISH) begin
            if (!slot_active(s) || done_flag[s]) begin
                add_result(toqm_pkg::KIND_IGNORED, 0, '0, '0);
            end else begin
                done_flag[s] = 1'b1;
                merge_dispatch();
            end
        end else if (c.cmd == toqm_pkg::CMD_FLUSH) begin
            any = 1'b0;
            for (int k = 0; k < SLOTS; k++)
                if (slot_active(k) && !done_flag[k]) begin
                    done_flag[k] = 1'b1;
                    any = 1'b1;
                end
            if (any) merge_dispatch();
        end else begin
            add_result(toqm_pkg::KIND_IGNORED, 0, '0, '0);
        end
        if (results_this_cmd > 0)
            expected_results[expected_results.size() - 1].last = 1'b1;
    endfunction

    function automatic void apply_config(logic [2:0] idx, logic [3:0] val);
        if (idx == toqm_pkg::REG_LIVE) begin
            for (int s = 0; s < SLOTS; s++)
                if (val[s] != live[s]) empty_slot(s);
            live = val;
        end else if (idx >= toqm_pkg::REG_TRAJ0 && idx <= toqm_pkg::REG_TRAJ3) begin
            traj_of[idx - toqm_pkg::REG_TRAJ0] = val[1:0];
        end
    endfunction

    // Command driver: takes pending commands and offers them on the port.
    always @(posedge i_clk) begin
        bit took;
        if (!i_rst_n) begin
            start <= 1'b0;
        end else begin
            took = start && !busy;
            if (took) predict_merge(held_cmd);
            if (!start || took) begin
                if (pending_cmds.size() > 0 && $urandom_range(99) >= idle_pct) begin
                    held_cmd = pending_cmds.pop_front();
                    start <= 1'b1;
                    i_cmd <= held_cmd.cmd;
                    i_slot <= held_cmd.slot;
                    i_timestamp <= held_cmd.ts;
                    i_payload <= held_cmd.word;
                end else begin
                    start <= 1'b0;
                end
            end
        end
    end

    // Result monitor: every strobe is one transfer checked against the model.
    always @(posedge i_clk) begin
        t_merge_result want;
        bit bad;
        if (i_rst_n && o_valid) begin
            if (expected_results.size() == 0) begin
                error_count++;
                if (error_count <= 10)
                    $display("Unexpected result: kind %0d slot %0d ts %h word %h",
                             o_kind, o_out_slot, o_out_timestamp, o_out_payload);
            end else begin
                want = expected_results.pop_front();
                bad = (o_kind !== want.kind) || (o_out_slot !== want.slot)
                      || (o_out_timestamp !== want.ts)
                      || (o_out_payload !== want.word) || (o_last !== want.last);
                if (bad) begin
                    error_count++;
                    if (error_count <= 10) begin
                        $display("Mismatch: expected kind %0d slot %0d ts %h word %h last %0d",
                                 want.kind, want.slot, want.ts, want.word, want.last);
                        $display("          got kind %0d slot %0d ts %h word %h last %0d",
                                 o_kind, o_out_slot, o_out_timestamp,
                                 o_out_payload, o_last);
                    end
                end
            end
        end
    end

    // Watchdog on the total run length.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    task automatic write_reg(logic [2:0] idx, logic [3:0] val);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        forever begin
            @(posedge i_clk);
            if (i_cfg_valid && o_cfg_ready) break;
        end
        apply_config(idx, val);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic configure(logic [3:0] mask, logic [1:0] t0, logic [1:0] t1,
                             logic [1:0] t2, logic [1:0] t3);
        write_reg(toqm_pkg::REG_LIVE, mask);
        write_reg(toqm_pkg::REG_TRAJ0, {2'b00, t0});
        write_reg(toqm_pkg::REG_TRAJ0 + 3'd1, {2'b00, t1});
        write_reg(toqm_pkg::REG_TRAJ0 + 3'd2, {2'b00, t2});
        write_reg(toqm_pkg::REG_TRAJ3, {2'b00, t3});
    endtask

    task automatic wait_drained();
        do @(posedge i_clk);
        while (pending_cmds.size() > 0 || start || expected_results.size() > 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    function automatic void queue_cmd(logic [1:0] c, logic [1:0] s,
                                      logic [47:0] t, logic [31:0] w);
        t_command x;
        x.cmd = c;
        x.slot = s;
        x.ts = t;
        x.word = w;
        pending_cmds.insert(pending_cmds.size(), x);
    endfunction

    // Mostly rising timestamps on random slots with some noise mixed in.
    function automatic void queue_random(int n, logic [47:0] base);
        int          r;
        logic [47:0] t;
        for (int i = 0; i < n; i++) begin
            r = int'($urandom_range(99));
            t = base + 48'($urandom_range(0, 40));
            base += 48'($urandom_range(0, 25));
            if (r < 70)
                queue_cmd(toqm_pkg::CMD_PUSH, 2'($urandom_range(3)), t, $urandom);
            else if (r < 78)
                queue_cmd(toqm_pkg::CMD_PUSH, 2'($urandom_range(3)),
                          48'({$urandom, $urandom}), $urandom);
            else if (r < 82)
                queue_cmd(toqm_pkg::CMD_PUSH, 2'($urandom_range(3)),
                          base - 48'($urandom_range(0, 200)), $urandom);
            else if (r < 96)
                queue_cmd(toqm_pkg::CMD_FINISH, 2'($urandom_range(3)),
                          48'({$urandom, $urandom}), $urandom);
            else
                queue_cmd(toqm_pkg::CMD_FLUSH, 2'($urandom_range(3)),
                          48'({$urandom, $urandom}), $urandom);
        end
    endfunction

    initial begin
        int idle_plan[6] = '{0, 72, 21, 0, 72, 21};
        for (int s = 0; s < SLOTS; s++) begin
            empty_slot(s);
            traj_of[s] = '0;
        end
        for (int k = 0; k < 4; k++) begin
            traj_started[k] = 1'b0;
            traj_start[k] = '0;
        end
        last_sent = '0;
        live = '0;

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part: overflow, extremes, double finish, flush, retired slot.
        configure(4'hF, 2'd0, 2'd0, 2'd1, 2'd3);
        for (int i = 0; i < 9; i++)
            queue_cmd(toqm_pkg::CMD_PUSH, 2'd1, 48'd10 + 48'(i * 10),
                      32'hA000_0000 + 32'(i));
        queue_cmd(toqm_pkg::CMD_PUSH, 2'd0, 48'd0, 32'h0000_0000);
        queue_cmd(toqm_pkg::CMD_PUSH, 2'd2, TS_MAX, 32'hFFFF_FFFF);
        queue_cmd(toqm_pkg::CMD_PUSH, 2'd3, 48'd50, 32'h5555_AAAA);
        queue_cmd(toqm_pkg::CMD_FINISH, 2'd0, 48'd0, 32'd0);
        queue_cmd(toqm_pkg::CMD_FINISH, 2'd0, TS_MAX, 32'hFFFF_FFFF);
        queue_cmd(toqm_pkg::CMD_PUSH, 2'd0, 48'd60, 32'h1234_5678);
        queue_cmd(toqm_pkg::CMD_PUSH, 2'd3, 48'd5, 32'h0BAD_0001);
        queue_cmd(toqm_pkg::CMD_FLUSH, 2'd3, 48'd0, 32'd0);
        queue_cmd(toqm_pkg::CMD_PUSH, 2'd1, 48'd999, 32'd7);
        queue_cmd(toqm_pkg::CMD_FINISH, 2'd2, 48'd0, 32'd0);
        queue_cmd(toqm_pkg::CMD_FLUSH, 2'd0, 48'd0, 32'd0);
        wait_drained();

        configure(4'h0, 2'd3, 2'd3, 2'd3, 2'd3);
        queue_cmd(toqm_pkg::CMD_PUSH, 2'd2, 48'd1, 32'd1);
        queue_cmd(toqm_pkg::CMD_FINISH, 2'd3, 48'd0, 32'd0);
        queue_cmd(toqm_pkg::CMD_FLUSH, 2'd1, 48'd0, 32'd0);
        wait_drained();

        // Random phases under different idle rates and settings.
        for (int p = 0; p < 6; p++) begin
            idle_pct = 0;
            if (p == 2)
                configure(4'hF, 2'd3, 2'd0, 2'd3, 2'd0);
            else
                configure(4'($urandom_range(1, 15)), 2'($urandom_range(3)),
                          2'($urandom_range(3)), 2'($urandom_range(3)),
                          2'($urandom_range(3)));
            idle_pct = idle_plan[p];
            queue_random(24, 48'({$urandom, $urandom} >> $urandom_range(0, 40)));
            wait_drained();
        end

        if (error_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
